[design/wpe_pkg.sv]
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared codes, widths and controller/datapath handshake structs for the
// weighted pick block.
// ----------------------------------------------------------------------------
package wpe_pkg;

  // fixed field widths
  localparam int DRAW_BITS    = 17;
  localparam int FRAC_BITS    = 16;
  localparam int OP_BITS      = 2;
  localparam int STATUS_BITS  = 2;
  localparam int MUL_CNT_BITS = $clog2(DRAW_BITS + 1);

  // draw value for exactly one in q1.16
  localparam logic [DRAW_BITS-1:0] ONE_Q16 = 17'h10000;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_BITS-1:0] OP_PICK   = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_ZERO = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;       // capture input beat, reset sum pass
    logic clear;       // empty the table
    logic append;      // write new entry at the fill count
    logic sum_step;    // one step of the total pass
    logic mul_start;   // start draw * total
    logic mul_step;    // one bit of draw * total
    logic walk_start;  // reset the selection pass
    logic walk_step;   // one step of the selection pass
    logic res_load;    // load result id register
    logic res_pick;    // result id is the picked id (else zero)
  } wpe_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               w_zero;
    logic               full;
    logic               pass_done;
    logic               total_zero;
    logic               mul_done;
    logic               hit;
    logic               any;
  } wpe_sts_t;

endpackage

[design/wpe_if.sv]
// ----------------------------------------------------------------------------
// wpe_in_if / wpe_out_if
// Valid/ready channels for input items and result items of the weighted
// pick block.
// ----------------------------------------------------------------------------
interface wpe_in_if #(
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
);
  import wpe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     operation;
  logic [ID_BITS-1:0]     entry_id;
  logic [WEIGHT_BITS-1:0] entry_weight;
  logic [DRAW_BITS-1:0]   draw;
  logic [ID_BITS-1:0]     exclude_id;

  modport source (
    output valid, operation, entry_id, entry_weight, draw, exclude_id,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_id, entry_weight, draw, exclude_id,
    output ready
  );
endinterface

interface wpe_out_if #(
  parameter int ID_BITS = 16
);
  import wpe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ID_BITS-1:0]     picked_id;
  logic [STATUS_BITS-1:0] status;

  modport source (
    output valid, picked_id, status,
    input  ready
  );

  modport sink (
    input  valid, picked_id, status,
    output ready
  );
endinterface

[design/wpe_ram.sv]
// ----------------------------------------------------------------------------
// wpe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/wpe_datapath.sv]
// ----------------------------------------------------------------------------
// wpe_datapath
// Entry table, fill count, read sequencer, total accumulator, shift-add
// multiplier for draw * total, and the selection walk.
// ----------------------------------------------------------------------------
module wpe_datapath #(
  parameter int TABLE_DEPTH = 256,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wpe_pkg::wpe_cmd_t               cmd_i,
  output wpe_pkg::wpe_sts_t               sts_o,
  input  logic [wpe_pkg::OP_BITS-1:0]     operation_i,
  input  logic [ID_BITS-1:0]              entry_id_i,
  input  logic [WEIGHT_BITS-1:0]          entry_weight_i,
  input  logic [wpe_pkg::DRAW_BITS-1:0]   draw_i,
  input  logic [ID_BITS-1:0]              exclude_id_i,
  output logic [ID_BITS-1:0]              res_id_o
);
  import wpe_pkg::*;

  localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_BITS   = WEIGHT_BITS + CNT_BITS;
  localparam int PROD_BITS  = SUM_BITS + DRAW_BITS;
  localparam int ENTRY_BITS = ID_BITS + WEIGHT_BITS;
  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

  logic [OP_BITS-1:0]      op_q, op_d;
  logic [ID_BITS-1:0]      new_id_q, new_id_d;
  logic [WEIGHT_BITS-1:0]  new_w_q, new_w_d;
  logic [ID_BITS-1:0]      excl_q, excl_d;
  logic [DRAW_BITS-1:0]    draw_q, draw_d;
  logic [CNT_BITS-1:0]     count_q, count_d;
  logic [CNT_BITS-1:0]     addr_q, addr_d;
  logic                    rvalid_q, rvalid_d;
  logic [SUM_BITS-1:0]     total_q, total_d;
  logic [PROD_BITS-1:0]    tgt_q, tgt_d;
  logic [MUL_CNT_BITS-1:0] bit_cnt_q, bit_cnt_d;
  logic [SUM_BITS-1:0]     run_q, run_d;
  logic [ID_BITS-1:0]      pick_id_q, pick_id_d;
  logic                    any_q, any_d;
  logic                    hit_q, hit_d;
  logic [ID_BITS-1:0]      res_id_q, res_id_d;

  logic                    issue;
  logic                    more;
  logic [ENTRY_BITS-1:0]   rdata;
  logic [ID_BITS-1:0]      rd_id;
  logic [WEIGHT_BITS-1:0]  rd_w;
  logic                    eligible;
  logic [SUM_BITS-1:0]     run_sum;
  logic                    reach;
  logic [PROD_BITS-1:0]    addend;

  // entry table: id in the upper bits, weight in the lower bits
  wpe_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (count_q[ADDR_BITS-1:0]),
    .wdata_i ({new_id_q, new_w_q}),
    .re_i    (issue),
    .raddr_i (addr_q[ADDR_BITS-1:0]),
    .rdata_o (rdata)
  );

  // read sequencing and entry decode
  assign more     = addr_q < count_q;
  assign issue    = (cmd_i.sum_step || cmd_i.walk_step) && more;
  assign rd_id    = rdata[ENTRY_BITS-1:WEIGHT_BITS];
  assign rd_w     = rdata[WEIGHT_BITS-1:0];
  assign eligible = rvalid_q && (rd_id != excl_q);

  // running sum and threshold test: running * 65536 >= draw * total
  assign run_sum = run_q + SUM_BITS'(rd_w);
  assign reach   = {1'b0, run_sum, {FRAC_BITS{1'b0}}} >= tgt_q;
  assign addend  = draw_q[DRAW_BITS-1] ? PROD_BITS'(total_q) : '0;

  // next-state logic
  always_comb begin
    op_d      = op_q;
    new_id_d  = new_id_q;
    new_w_d   = new_w_q;
    excl_d    = excl_q;
    draw_d    = draw_q;
    count_d   = count_q;
    addr_d    = addr_q;
    rvalid_d  = issue;
    total_d   = total_q;
    tgt_d     = tgt_q;
    bit_cnt_d = bit_cnt_q;
    run_d     = run_q;
    pick_id_d = pick_id_q;
    any_d     = any_q;
    hit_d     = hit_q;
    res_id_d  = res_id_q;

    if (issue) begin
      addr_d = addr_q + 1'b1;
    end

    // capture beat, saturate draw, reset total pass
    if (cmd_i.latch) begin
      op_d     = operation_i;
      new_id_d = entry_id_i;
      new_w_d  = entry_weight_i;
      excl_d   = exclude_id_i;
      draw_d   = (draw_i > ONE_Q16) ? ONE_Q16 : draw_i;
      addr_d   = '0;
      rvalid_d = 1'b0;
      total_d  = '0;
      any_d    = 1'b0;
      hit_d    = 1'b0;
    end

    // table fill count
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append) begin
      count_d = count_q + 1'b1;
    end

    // total of eligible weights
    if (cmd_i.sum_step && eligible) begin
      total_d = total_q + SUM_BITS'(rd_w);
    end

    // shift-add multiply, draw msb first
    if (cmd_i.mul_start) begin
      tgt_d     = '0;
      bit_cnt_d = MUL_CNT_BITS'(DRAW_BITS);
    end else if (cmd_i.mul_step) begin
      tgt_d     = {tgt_q[PROD_BITS-2:0], 1'b0} + addend;
      draw_d    = {draw_q[DRAW_BITS-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - 1'b1;
    end

    // selection walk, frozen after the first hit
    if (cmd_i.walk_start) begin
      addr_d   = '0;
      rvalid_d = 1'b0;
      run_d    = '0;
      any_d    = 1'b0;
      hit_d    = 1'b0;
    end else if (cmd_i.walk_step && eligible && !hit_q) begin
      run_d     = run_sum;
      pick_id_d = rd_id;
      any_d     = 1'b1;
      hit_d     = reach;
    end

    // result id
    if (cmd_i.res_load) begin
      res_id_d = cmd_i.res_pick ? pick_id_q : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      addr_q    <= '0;
      rvalid_q  <= 1'b0;
      bit_cnt_q <= '0;
      any_q     <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      count_q   <= count_d;
      addr_q    <= addr_d;
      rvalid_q  <= rvalid_d;
      bit_cnt_q <= bit_cnt_d;
      any_q     <= any_d;
      hit_q     <= hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    new_id_q  <= new_id_d;
    new_w_q   <= new_w_d;
    excl_q    <= excl_d;
    draw_q    <= draw_d;
    total_q   <= total_d;
    tgt_q     <= tgt_d;
    run_q     <= run_d;
    pick_id_q <= pick_id_d;
    res_id_q  <= res_id_d;
  end

  // status to controller
  always_comb begin
    sts_o.op         = op_q;
    sts_o.w_zero     = (new_w_q == '0);
    sts_o.full       = (count_q >= DEPTH_CNT);
    sts_o.pass_done  = !more && !rvalid_q;
    sts_o.total_zero = (total_q == '0);
    sts_o.mul_done   = (bit_cnt_q == '0);
    sts_o.hit        = hit_q;
    sts_o.any        = any_q;
  end

  assign res_id_o = res_id_q;

endmodule

[design/wpe_ctrl.sv]
// ----------------------------------------------------------------------------
// wpe_ctrl
// Sequencer for clear, append and pick items; owns the result valid and
// status registers.
// ----------------------------------------------------------------------------
module wpe_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wpe_pkg::STATUS_BITS-1:0]  out_status_o,
  input  wpe_pkg::wpe_sts_t                sts_i,
  output wpe_pkg::wpe_cmd_t                cmd_o
);
  import wpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic                   out_free;

  // result register can take a new beat
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    cmd_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      // dispatch on the latched operation; clear, append and unused codes
      // finish here
      S_EXEC: begin
        if (sts_i.op == OP_PICK) begin
          state_d = S_SUM;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          status_d     = ST_OK;
          cmd_o.res_load = 1'b1;
          state_d      = S_IDLE;
          case (sts_i.op)
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            OP_APPEND: begin
              if (sts_i.w_zero) begin
                status_d = ST_ZERO;
              end else if (sts_i.full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      // first pass: total of eligible weights
      S_SUM: begin
        if (sts_i.pass_done) begin
          if (sts_i.total_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.mul_start = 1'b1;
            state_d         = S_MUL;
          end
        end else begin
          cmd_o.sum_step = 1'b1;
        end
      end
      // draw * total, one bit per cycle
      S_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      // second pass: first entry that reaches the threshold, else the last eligible
      S_WALK: begin
        if (sts_i.hit || sts_i.pass_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          status_d       = sts_i.any ? ST_OK : ST_NONE;
          cmd_o.res_load = 1'b1;
          cmd_o.res_pick = sts_i.any;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result status payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;

endmodule

[design/weighted_pick_excluding_one.sv]
// ----------------------------------------------------------------------------
// weighted_pick_excluding_one
// Table of (id, weight) entries with a roulette-wheel pick that leaves out
// one id. A clear or append item passes through a dispatch state, and its
// result is loaded once the output register is free. A pick runs from
// accept to result through a dispatch state, the total pass (one read of
// the entry RAM per cycle), a shift-add multiply of draw by total, the
// selection walk, and a final state that loads the result once the output
// register is free. The walk ends early at the first entry that reaches
// the threshold; a pick with no eligible weight skips the multiply and the
// walk. One item is worked at a time; a new item can be accepted in the
// same cycle as the previous result turns valid, while that result may
// still wait in the output register.
// ----------------------------------------------------------------------------
module weighted_pick_excluding_one #(
  parameter int TABLE_DEPTH = 256,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wpe_in_if.sink   in_i,
  wpe_out_if.source out_o
);
  import wpe_pkg::*;

  wpe_cmd_t cmd;
  wpe_sts_t sts;

  // sequencer
  wpe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // table and arithmetic
  wpe_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (in_i.operation),
    .entry_id_i     (in_i.entry_id),
    .entry_weight_i (in_i.entry_weight),
    .draw_i         (in_i.draw),
    .exclude_id_i   (in_i.exclude_id),
    .res_id_o       (out_o.picked_id)
  );

endmodule
